// ===== hw/rtl/thrc_pkg.sv =====
// Shared constants, types and arithmetic helpers for the terrain colour ramp.
// No dependencies; imported by the core and its checker.
`default_nettype none

package thrc_pkg;

    localparam int unsigned CH_W       = 8;   // colour channel and height width
    localparam int unsigned DIV_STEPS  = 3;   // quotient bits resolved per stage
    localparam int unsigned LATENCY    = 6;   // start edge to result edge

    // register indexes on the write port
    localparam logic [0:0] REG_SEA_LEVEL   = 1'b0;
    localparam logic [0:0] REG_SHOW_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // one restoring-division step
    typedef struct packed {
        logic            q;
        logic [CH_W-1:0] rem;
    } div_t;

    localparam rgb_t DEEP_BLUE    = '{r: 8'd10,  g: 8'd35,  b: 8'd80};
    localparam rgb_t SHALLOW_BLUE = '{r: 8'd60,  g: 8'd140, b: 8'd200};
    localparam rgb_t PLAINS_COL   = '{r: 8'd60,  g: 8'd160, b: 8'd80};
    localparam rgb_t HILLS_COL    = '{r: 8'd140, g: 8'd120, b: 8'd80};
    localparam rgb_t PEAK_COL     = '{r: 8'd210, g: 8'd210, b: 8'd210};
    localparam rgb_t WATERLINE    = '{r: 8'd255, g: 8'd80,  b: 8'd80};
    localparam rgb_t FIRE_COL     = '{r: 8'd220, g: 8'd120, b: 8'd40};
    localparam rgb_t COPPER_COL   = '{r: 8'd120, g: 8'd120, b: 8'd140};
    localparam rgb_t TIN_COL      = '{r: 8'd110, g: 8'd110, b: 8'd130};
    localparam rgb_t CLAY_COL     = '{r: 8'd160, g: 8'd80,  b: 8'd70};

    localparam logic [CH_W-1:0] COAST_GAIN   = 8'd20;
    localparam logic [CH_W-1:0] FOREST_GREEN = 8'd18;
    localparam logic [CH_W-1:0] FOREST_RED   = 8'd8;
    localparam logic [CH_W-1:0] FIELD_RED    = 8'd10;
    localparam logic [CH_W-1:0] FIELD_GREEN  = 8'd6;

    localparam logic [8:0]  HILL_KNEE = 9'd160;
    // n/5 = (n*3277)>>14 exact for n <= 1280; n/3 = (n*2731)>>13 exact for n <= 768
    localparam logic [11:0] RECIP5 = 12'd3277;
    localparam logic [11:0] RECIP3 = 12'd2731;

    function automatic logic [CH_W-1:0] sat_add(logic [CH_W-1:0] v, logic [CH_W-1:0] k);
        logic [CH_W:0] s;
        s = {1'b0, v} + {1'b0, k};
        return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
    endfunction

    // (a*(256-w) + b*w) >> 8, written as a*256 + (b-a)*w
    function automatic logic [CH_W-1:0] lerp8(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                             logic [8:0] w);
        logic signed [8:0]  diff;
        logic signed [9:0]  ws;
        logic signed [17:0] acc;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        ws   = $signed({1'b0, w});
        acc  = $signed({2'b00, a, 8'h00}) + diff * ws;
        return acc[15:8];
    endfunction

    function automatic rgb_t lerp_rgb(rgb_t a, rgb_t b, logic [8:0] w);
        rgb_t o;
        o.r = lerp8(a.r, b.r, w);
        o.g = lerp8(a.g, b.g, w);
        o.b = lerp8(a.b, b.b, w);
        return o;
    endfunction

    // num is the shifted partial remainder, always below 2*dv
    function automatic div_t div_step(logic [CH_W:0] num, logic [CH_W-1:0] dv);
        div_t          o;
        logic [CH_W:0] diff;
        diff = num - {1'b0, dv};
        if (num >= {1'b0, dv})
        begin
            o.q   = 1'b1;
            o.rem = diff[CH_W-1:0];
        end
        else
        begin
            o.q   = 1'b0;
            o.rem = num[CH_W-1:0];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/terrain_height_color_ramp_core.sv =====
// Terrain height colour ramp: tile height and flags to RGB, six-stage pipeline.
// Depends on thrc_pkg (constants, colour type, divide step, blend helpers).
//
// The result strobe (done) is start carried through vld_reg[0..4] and done_reg.
// Throughput: one transaction per cycle; busy stays low, since nothing in the
// pipeline can stall and the receiver takes every result as it appears.
// Reset: rst_n clears valid bits, done and config registers (waterline 0, debug off).
`default_nettype none

module terrain_height_color_ramp_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [thrc_pkg::CH_W-1:0]   cfg_wdata,
    // input transaction
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [thrc_pkg::CH_W-1:0]   height,
    input  wire logic                        is_coast,
    input  wire logic                        is_forest,
    input  wire logic                        is_field,
    input  wire logic                        is_fire,
    input  wire logic                        is_copper_mine,
    input  wire logic                        is_tin_mine,
    input  wire logic                        is_clay_pit,
    // result transaction
    output logic                             done,
    output logic [thrc_pkg::CH_W-1:0]        red,
    output logic [thrc_pkg::CH_W-1:0]        green,
    output logic [thrc_pkg::CH_W-1:0]        blue
);
    import thrc_pkg::*;

    // Overlay resolved to one code at entry; fire wins, clay loses.
    typedef enum logic [2:0] {OV_NONE, OV_FIRE, OV_COPPER, OV_TIN, OV_CLAY} overlay_t;
    // Which ramp segment the blend weight belongs to.
    typedef enum logic [1:0] {SEG_WATER, SEG_PLAINS, SEG_HILLS} seg_t;

    // Side-band that rides along with every transaction.
    typedef struct packed {
        logic            water;
        logic            debug;
        logic            hit;     // height within one of the waterline
        logic [CH_W-1:0] h;
        logic            coast;
        logic            forest;
        logic            field;
        overlay_t        ov;
    } tag_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CH_W-1:0] sea_height_reg;
    logic            show_height_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sea_height_reg       <= '0;
            show_height_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEA_LEVEL:   sea_height_reg       <= cfg_wdata;
                REG_SHOW_HEIGHT: show_height_mode_reg <= cfg_wdata[0];
            endcase
        end
    end

    assign busy = 1'b0;

    wire logic accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: classify, pick dividend/divisor, quotient bits 8..6
    // Water: q = depth*256/sea; land: q = elevation*256/(255-sea).
    // The dividend never exceeds the divisor, so q fits in 0..256.
    // ------------------------------------------------------------------
    logic [4:0]      vld_reg;       // valid bits of stages 1..5
    tag_t            s1_tag_next, s1_tag_reg;
    logic [CH_W-1:0] s1_dv_next,  s1_dv_reg;
    logic [CH_W-1:0] s1_rem_next, s1_rem_reg;
    logic [2:0]      s1_q_next,   s1_q_reg;

    always_comb
    begin
        logic [CH_W-1:0] x;
        logic [CH_W:0]   h_p1;
        logic [CH_W:0]   s_p1;
        div_t            st;

        s1_tag_next.water  = (height < sea_height_reg);
        s1_tag_next.debug  = show_height_mode_reg;
        h_p1               = {1'b0, height} + 9'd1;
        s_p1               = {1'b0, sea_height_reg} + 9'd1;
        s1_tag_next.hit    = (height == sea_height_reg) || (h_p1 == {1'b0, sea_height_reg})
                             || (s_p1 == {1'b0, height});
        s1_tag_next.h      = height;
        s1_tag_next.coast  = is_coast;
        s1_tag_next.forest = is_forest;
        s1_tag_next.field  = is_field;
        if (is_fire)             s1_tag_next.ov = OV_FIRE;
        else if (is_copper_mine) s1_tag_next.ov = OV_COPPER;
        else if (is_tin_mine)    s1_tag_next.ov = OV_TIN;
        else if (is_clay_pit)    s1_tag_next.ov = OV_CLAY;
        else                     s1_tag_next.ov = OV_NONE;

        if (s1_tag_next.water)
        begin
            x          = sea_height_reg - height;
            s1_dv_next = sea_height_reg;
        end
        else
        begin
            x          = height - sea_height_reg;
            // 255 - sea, or 1 at the top of the range
            s1_dv_next = (sea_height_reg == {CH_W{1'b1}}) ? 8'd1 : ~sea_height_reg;
        end

        st           = div_step({1'b0, x}, s1_dv_next);
        s1_q_next[2] = st.q;
        s1_rem_next  = st.rem;
        for (int i = 1; i < DIV_STEPS; i++)
        begin
            st                = div_step({s1_rem_next, 1'b0}, s1_dv_next);
            s1_q_next[2 - i]  = st.q;
            s1_rem_next       = st.rem;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient bits 5..3
    // ------------------------------------------------------------------
    tag_t            s2_tag_reg;
    logic [CH_W-1:0] s2_dv_reg;
    logic [CH_W-1:0] s2_rem_next, s2_rem_reg;
    logic [5:0]      s2_q_next,   s2_q_reg;

    always_comb
    begin
        div_t st;
        s2_rem_next = s1_rem_reg;
        s2_q_next   = {s1_q_reg, 3'b000};
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            st               = div_step({s2_rem_next, 1'b0}, s1_dv_reg);
            s2_q_next[2 - i] = st.q;
            s2_rem_next      = st.rem;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient bits 2..0 (remainder no longer needed)
    // ------------------------------------------------------------------
    tag_t       s3_tag_reg;
    logic [8:0] s3_q_next, s3_q_reg;

    always_comb
    begin
        div_t            st;
        logic [CH_W-1:0] rem;
        rem       = s2_rem_reg;
        s3_q_next = {s2_q_reg, 3'b000};
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            st               = div_step({rem, 1'b0}, s2_dv_reg);
            s3_q_next[2 - i] = st.q;
            rem              = st.rem;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: blend weight. Water: 256-q. Land: rescale t=q onto the
    // plains segment (t*8/5) or the hills segment ((t-160)*8/3).
    // ------------------------------------------------------------------
    tag_t       s4_tag_reg;
    logic [8:0] s4_w_next, s4_w_reg;
    seg_t       s4_seg_next, s4_seg_reg;

    always_comb
    begin
        logic [8:0]  t;
        logic [8:0]  u;
        logic [23:0] prod_lo;
        logic [21:0] prod_hi;

        t       = s3_tag_reg.water ? (9'd256 - s3_q_reg) : s3_q_reg;
        u       = t - HILL_KNEE;
        prod_lo = {12'd0, t, 3'b000} * {12'd0, RECIP5};
        prod_hi = {12'd0, u[6:0], 3'b000} * {10'd0, RECIP3};

        if (s3_tag_reg.water)
        begin
            s4_seg_next = SEG_WATER;
            s4_w_next   = t;
        end
        else if (t > HILL_KNEE)
        begin
            s4_seg_next = SEG_HILLS;
            s4_w_next   = prod_hi[21:13];
        end
        else
        begin
            s4_seg_next = SEG_PLAINS;
            s4_w_next   = prod_lo[22:14];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: blend between the segment's two end colours
    // ------------------------------------------------------------------
    tag_t s5_tag_reg;
    rgb_t s5_rgb_next, s5_rgb_reg;

    always_comb
    begin
        case (s4_seg_reg)
            SEG_WATER:  s5_rgb_next = lerp_rgb(DEEP_BLUE,  SHALLOW_BLUE, s4_w_reg);
            SEG_PLAINS: s5_rgb_next = lerp_rgb(PLAINS_COL, HILLS_COL,    s4_w_reg);
            SEG_HILLS:  s5_rgb_next = lerp_rgb(HILLS_COL,  PEAK_COL,     s4_w_reg);
            default:    s5_rgb_next = lerp_rgb(PLAINS_COL, HILLS_COL,    s4_w_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 6 (output): coast brightening, land tints, debug view, overlays
    // ------------------------------------------------------------------
    rgb_t col_next;
    logic done_reg;
    rgb_t out_rgb_reg;

    always_comb
    begin
        col_next = s5_rgb_reg;
        if (s5_tag_reg.debug)
        begin
            col_next = s5_tag_reg.hit ? WATERLINE
                                      : rgb_t'{r: s5_tag_reg.h, g: s5_tag_reg.h, b: s5_tag_reg.h};
        end
        else if (s5_tag_reg.water)
        begin
            if (s5_tag_reg.coast)
            begin
                col_next.r = sat_add(col_next.r, COAST_GAIN);
                col_next.g = sat_add(col_next.g, COAST_GAIN);
                col_next.b = sat_add(col_next.b, COAST_GAIN);
            end
        end
        else
        begin
            // forest first, then field on top
            if (s5_tag_reg.forest)
            begin
                col_next.g = sat_add(col_next.g, FOREST_GREEN);
                if (col_next.r > FOREST_RED)
                    col_next.r = col_next.r - FOREST_RED;
            end
            if (s5_tag_reg.field)
            begin
                col_next.r = sat_add(col_next.r, FIELD_RED);
                col_next.g = sat_add(col_next.g, FIELD_GREEN);
            end
        end

        case (s5_tag_reg.ov)
            OV_FIRE:   col_next = FIRE_COL;
            OV_COPPER: col_next = COPPER_COL;
            OV_TIN:    col_next = TIN_COL;
            OV_CLAY:   col_next = CLAY_COL;
            default:   ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline registers: valid bits reset, payload free-running
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[3:0], accept};
            done_reg <= vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= s1_tag_next;
        s1_dv_reg   <= s1_dv_next;
        s1_rem_reg  <= s1_rem_next;
        s1_q_reg    <= s1_q_next;

        s2_tag_reg  <= s1_tag_reg;
        s2_dv_reg   <= s1_dv_reg;
        s2_rem_reg  <= s2_rem_next;
        s2_q_reg    <= s2_q_next;

        s3_tag_reg  <= s2_tag_reg;
        s3_q_reg    <= s3_q_next;

        s4_tag_reg  <= s3_tag_reg;
        s4_w_reg    <= s4_w_next;
        s4_seg_reg  <= s4_seg_next;

        s5_tag_reg  <= s4_tag_reg;
        s5_rgb_reg  <= s5_rgb_next;

        out_rgb_reg <= col_next;
    end

    assign done  = done_reg;
    assign red   = out_rgb_reg.r;
    assign green = out_rgb_reg.g;
    assign blue  = out_rgb_reg.b;

endmodule

`default_nettype wire

// ===== hw/rtl/thrc_checker.sv =====
// Port-level checks for the terrain colour ramp core, attached by bind.
// Depends on thrc_pkg (latency, overlay colour).
`default_nettype none

module thrc_checker
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic                      is_fire,
    input  wire logic                      done,
    input  wire logic [thrc_pkg::CH_W-1:0] red,
    input  wire logic [thrc_pkg::CH_W-1:0] green,
    input  wire logic [thrc_pkg::CH_W-1:0] blue
);
    import thrc_pkg::*;

    // every accepted transaction yields exactly one result
    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction produced no result");

    a_done_has_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching transaction");

    // fire overrides every other colour source
    a_fire_colour: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_fire) |-> ##LATENCY
            (red == FIRE_COL.r && green == FIRE_COL.g && blue == FIRE_COL.b))
        else $error("fire overlay colour wrong");

    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result strobe straight out of reset");

endmodule

bind terrain_height_color_ramp_core thrc_checker u_thrc_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .is_fire (is_fire),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue)
);

`default_nettype wire
